### src/weighted_mean_square_error_defines.svh
// ----------------------------------------------------------------------------
// Weighted MSE assertion macros
// Shared concurrent assertion helpers for the weighted MSE block.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MEAN_SQUARE_ERROR_DEFINES_SVH
`define WEIGHTED_MEAN_SQUARE_ERROR_DEFINES_SVH

// Check that cond implies prop in the same cycle.
`define WMSE_ASSERT_IMPL(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("weighted MSE check failed");

// Check that cond implies prop in the following cycle.
`define WMSE_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("weighted MSE check failed");

`endif

### src/wmse_pkg.sv
// ----------------------------------------------------------------------------
// Weighted MSE package
// Widths, limits and shared types of the weighted MSE block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmse_pkg;

	localparam int MAX_PIXELS_LOG2 = 23;

	localparam int PIX_W    = 8;
	localparam int WEIGHT_W = 16;
	localparam int DSQ_W    = 2 * PIX_W;
	localparam int TERM_W   = DSQ_W + WEIGHT_W;
	localparam int SQ_SUM_W = 32 + MAX_PIXELS_LOG2;
	localparam int W_SUM_W  = WEIGHT_W + MAX_PIXELS_LOG2;

	localparam int FRAC_W     = 8;
	localparam int DIVIDEND_W = SQ_SUM_W + FRAC_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	localparam int               MSE_W   = 24;
	localparam logic [MSE_W-1:0] MSE_MAX = 24'd16646400;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	typedef struct packed {
		logic [SQ_SUM_W-1:0] sq_sum;
		logic [W_SUM_W-1:0]  w_sum;
	} frame_sums_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DELIVER
	} div_state_t;

endpackage

`default_nettype wire

### src/wmse_front.sv
// ----------------------------------------------------------------------------
// Weighted MSE front end
// Squares pixel differences, weights them and accumulates frame sums.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_front (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [wmse_pkg::PIX_W-1:0]       ref_pixel,
	input  wire  [wmse_pkg::PIX_W-1:0]       test_pixel,
	input  wire  [wmse_pkg::WEIGHT_W-1:0]    weight,
	input  wire                              last_pixel,
	input  wire  wmse_pkg::fifo_status_t     fifo_status,
	output logic                             push,
	output wmse_pkg::frame_sums_t            push_sums
);
	import wmse_pkg::*;

	logic                adv;
	logic [PIX_W-1:0]    diff;
	logic                s1_valid_s1, s1_last_s1;
	logic [DSQ_W-1:0]    dsq_s1;
	logic [WEIGHT_W-1:0] w_s1;
	logic                s2_valid_s2, s2_last_s2;
	logic [TERM_W-1:0]   term_s2;
	logic [WEIGHT_W-1:0] w_s2;
	logic [SQ_SUM_W-1:0] sq_sum_q;
	logic [W_SUM_W-1:0]  w_sum_q;
	logic [SQ_SUM_W:0]   sq_ext;
	logic [W_SUM_W:0]    w_ext;
	logic [SQ_SUM_W-1:0] sq_next;
	logic [W_SUM_W-1:0]  w_next;

	// Hold the whole pipe while a finished frame waits for queue space.
	assign adv      = !(s2_valid_s2 && s2_last_s2 && fifo_status.full);
	assign in_ready = adv;

	assign diff = (ref_pixel >= test_pixel) ? (ref_pixel - test_pixel)
	                                        : (test_pixel - ref_pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			s2_valid_s2 <= 1'b0;
		end else if (adv) begin
			s1_valid_s1 <= in_valid;
			s2_valid_s2 <= s1_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dsq_s1     <= DSQ_W'(diff) * DSQ_W'(diff);
			w_s1       <= weight;
			s1_last_s1 <= last_pixel;
			term_s2    <= TERM_W'(dsq_s1) * TERM_W'(w_s1);
			w_s2       <= w_s1;
			s2_last_s2 <= s1_last_s1;
		end
	end

	// Saturating accumulate: a carry out pins the sum at all ones.
	assign sq_ext  = {1'b0, sq_sum_q} + (SQ_SUM_W+1)'(term_s2);
	assign w_ext   = {1'b0, w_sum_q} + (W_SUM_W+1)'(w_s2);
	assign sq_next = sq_ext[SQ_SUM_W] ? {SQ_SUM_W{1'b1}} : sq_ext[SQ_SUM_W-1:0];
	assign w_next  = w_ext[W_SUM_W] ? {W_SUM_W{1'b1}} : w_ext[W_SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_sum_q <= '0;
			w_sum_q  <= '0;
		end else if (adv && s2_valid_s2) begin
			if (s2_last_s2) begin
				sq_sum_q <= '0;
				w_sum_q  <= '0;
			end else begin
				sq_sum_q <= sq_next;
				w_sum_q  <= w_next;
			end
		end
	end

	assign push             = adv && s2_valid_s2 && s2_last_s2;
	assign push_sums.sq_sum = sq_next;
	assign push_sums.w_sum  = w_next;

endmodule

`default_nettype wire

### src/wmse_fifo.sv
// ----------------------------------------------------------------------------
// Weighted MSE frame queue
// Short queue of finished frame sums between front end and divider.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_fifo (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              push,
	input  wire  wmse_pkg::frame_sums_t      push_sums,
	input  wire                              pop,
	output wmse_pkg::frame_sums_t            head,
	output wmse_pkg::fifo_status_t           status
);
	import wmse_pkg::*;

	frame_sums_t        entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push, do_pop;

	assign status.full  = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_sums;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### src/wmse_div.sv
// ----------------------------------------------------------------------------
// Weighted MSE divider
// Bit-serial quotient of frame sums in Q16.8 with saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmse_div (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire  wmse_pkg::frame_sums_t      head,
	input  wire  wmse_pkg::fifo_status_t     fifo_status,
	output logic                             pop,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic [wmse_pkg::MSE_W-1:0]       mean_sq_error,
	output logic                             zero_weight
);
	import wmse_pkg::*;

	div_state_t            state_q, state_d;
	logic [DIVIDEND_W-1:0] num_q;
	logic [W_SUM_W-1:0]    den_q;
	logic [W_SUM_W-1:0]    rem_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  zero_q;
	logic [W_SUM_W:0]      shifted;
	logic                  ge;
	logic [W_SUM_W-1:0]    sub;
	logic                  out_free, step, load_out, last_step;
	logic [MSE_W-1:0]      result;

	assign shifted   = {rem_q, num_q[DIVIDEND_W-1]};
	assign ge        = (shifted >= {1'b0, den_q});
	// When ge holds the difference is below den_q, so the low bits suffice.
	assign sub       = shifted[W_SUM_W-1:0] - den_q;
	assign out_free  = !out_valid || out_ready;
	assign last_step = (cnt_q == DIV_CNT_W'(DIVIDEND_W - 1));
	assign result    = zero_q ? '0 :
	                   (quo_q > DIVIDEND_W'(MSE_MAX)) ? MSE_MAX : quo_q[MSE_W-1:0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DIV_IDLE: begin
				if (!fifo_status.empty) begin
					state_d = (head.w_sum == '0) ? DIV_DELIVER : DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (last_step) begin
					state_d = DIV_DELIVER;
				end
			end
			DIV_DELIVER: begin
				if (out_free) begin
					state_d = DIV_IDLE;
				end
			end
			default: state_d = DIV_IDLE;
		endcase
	end

	always_comb begin
		pop      = 1'b0;
		step     = 1'b0;
		load_out = 1'b0;
		unique case (state_q)
			DIV_IDLE:    pop      = !fifo_status.empty;
			DIV_RUN:     step     = 1'b1;
			DIV_DELIVER: load_out = out_free;
			default:     pop      = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= DIV_IDLE;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			num_q  <= {head.sq_sum, FRAC_W'(0)};
			den_q  <= head.w_sum;
			rem_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			zero_q <= (head.w_sum == '0);
		end else if (step) begin
			num_q <= {num_q[DIVIDEND_W-2:0], 1'b0};
			rem_q <= ge ? sub : shifted[W_SUM_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
			cnt_q <= cnt_q + 1'b1;
		end
		if (load_out) begin
			mean_sq_error <= result;
			zero_weight   <= zero_q;
		end
	end

endmodule

`default_nettype wire

### src/weighted_mean_square_error.sv
// ----------------------------------------------------------------------------
// Weighted mean squared error
// Pixels: one transfer per cycle while s_tready is high; a last pixel passes stage
// registers s1 and s2 into the frame queue. A frame with a nonzero weight sum gets
// bit-serial division (one quotient bit per cycle, 55-bit sum plus 8 fraction bits);
// the divider takes a frame only after loading the previous result, so short frames
// throttle the input once the queue fills. arst_n clears sums, queue and output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "weighted_mean_square_error_defines.svh"

module weighted_mean_square_error (
	input  wire         clk,
	input  wire         arst_n,
	// Pixel stream in
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [31:0] s_tdata,   // ref_pixel[7:0], test_pixel[15:8], weight[31:16]
	input  wire         s_tlast,   // last_pixel
	// Frame result out
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [23:0] m_tdata,   // mean_sq_error[23:0]
	output logic        m_tuser    // zero_weight
);
	import wmse_pkg::*;

	fifo_status_t fifo_status;
	frame_sums_t  push_sums, head;
	logic         push, pop;

	// Front end: square, weight and accumulate; stall only on a full queue.
	wmse_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.ref_pixel   (s_tdata[7:0]),
		.test_pixel  (s_tdata[15:8]),
		.weight      (s_tdata[31:16]),
		.last_pixel  (s_tlast),
		.fifo_status (fifo_status),
		.push        (push),
		.push_sums   (push_sums)
	);

	// Queue of completed frame sums; decouples pixel intake from division.
	wmse_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_sums (push_sums),
		.pop       (pop),
		.head      (head),
		.status    (fifo_status)
	);

	// Back end: divide, saturate and hold the result until the transfer.
	wmse_div u_div (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.fifo_status   (fifo_status),
		.pop           (pop),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.mean_sq_error (m_tdata),
		.zero_weight   (m_tuser)
	);

	// A zero-weight frame always reports a zero mean.
	`WMSE_ASSERT_IMPL(a_zero_flag_data, clk, arst_n, m_tvalid && m_tuser, m_tdata == '0)
	// The result never exceeds the saturation limit.
	`WMSE_ASSERT_IMPL(a_result_limit, clk, arst_n, m_tvalid, m_tdata <= MSE_MAX)
	// Input stalls only because the frame queue is full.
	`WMSE_ASSERT_IMPL(a_stall_cause, clk, arst_n, !s_tready, fifo_status.full)
	// A pop empties the queue head into the divider, never from an empty queue.
	`WMSE_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, !fifo_status.empty)

endmodule

`default_nettype wire
